// File: sv/sspc_pkg.sv
// shared types, constants and codes for the servo slew position controller
package sspc_pkg;

    localparam int ANGLE_W     = 9;
    localparam int PULSE_W     = 12;
    localparam int CMD_W       = 3;
    localparam int STATUS_W    = 2;
    localparam int ANGLE_LIMIT = 511;

    // percent to angle: (value*270 + 50) / 100 as one multiply by a reciprocal
    localparam int PCT_MAX     = 100;
    localparam int PCT_FULL    = 270;
    localparam int PCT_RECIP   = 5243;
    localparam int PCT_SHIFT   = 19;
    localparam int PCT_MUL     = PCT_FULL * PCT_RECIP;
    localparam int PCT_BIAS    = (PCT_MAX / 2) * PCT_RECIP;
    localparam int PCT_PROD_W  = 30;

    localparam int APB_AW      = 4;
    localparam int APB_DW      = 32;

    localparam logic [1:0] REG_MIN_PULSE = 2'd0;
    localparam logic [1:0] REG_MAX_PULSE = 2'd1;
    localparam logic [1:0] REG_MAX_ANGLE = 2'd2;
    localparam logic [1:0] REG_REVERSED  = 2'd3;

    localparam logic [PULSE_W-1:0] MIN_PULSE_RST = 12'd544;
    localparam logic [PULSE_W-1:0] MAX_PULSE_RST = 12'd2400;
    localparam logic [ANGLE_W-1:0] MAX_ANGLE_RST = 9'd270;

    localparam logic [CMD_W-1:0] CMD_TICK  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_GOTO  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PCT   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_OPEN  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLOSE = 3'd4;
    localparam logic [CMD_W-1:0] CMD_STOP  = 3'd5;

    localparam logic [1:0] OP_NOP  = 2'd0;
    localparam logic [1:0] OP_TICK = 2'd1;
    localparam logic [1:0] OP_GOTO = 2'd2;
    localparam logic [1:0] OP_STOP = 2'd3;

    localparam logic [STATUS_W-1:0] STAT_CLOSED  = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_CLOSING = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_OPENING = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_OPEN    = 2'd3;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    localparam int PROD_W      = ANGLE_W + PULSE_W;
    localparam int DIVD_W      = PROD_W + 1;
    localparam int DIVS_W      = ANGLE_W + 1;
    localparam int DCNT_W      = 5;
    localparam int RES_W       = 24;

    typedef struct packed {
        logic [PULSE_W-1:0] min_pulse;
        logic [PULSE_W-1:0] max_pulse;
        logic [ANGLE_W-1:0] max_angle;
        logic               reversed;
    } cfg_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic [ANGLE_W-1:0] angle;
    } op_t;

endpackage

// File: sv/sspc_cfg.sv
// apb configuration registers
module sspc_cfg import sspc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    logic [PULSE_W-1:0] min_pulse_reg;
    logic [PULSE_W-1:0] max_pulse_reg;
    logic [ANGLE_W-1:0] max_angle_reg;
    logic               reversed_reg;
    logic [1:0]         reg_idx;
    logic               wr_en;

    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_pulse_reg <= MIN_PULSE_RST;
            max_pulse_reg <= MAX_PULSE_RST;
            max_angle_reg <= MAX_ANGLE_RST;
            reversed_reg  <= 1'b0;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_MIN_PULSE: min_pulse_reg <= pwdata[PULSE_W-1:0];
                REG_MAX_PULSE: max_pulse_reg <= pwdata[PULSE_W-1:0];
                REG_MAX_ANGLE: max_angle_reg <= pwdata[ANGLE_W-1:0];
                REG_REVERSED:  reversed_reg  <= pwdata[0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_MIN_PULSE: prdata = {{(APB_DW-PULSE_W){1'b0}}, min_pulse_reg};
            REG_MAX_PULSE: prdata = {{(APB_DW-PULSE_W){1'b0}}, max_pulse_reg};
            REG_MAX_ANGLE: prdata = {{(APB_DW-ANGLE_W){1'b0}}, max_angle_reg};
            REG_REVERSED:  prdata = {{(APB_DW-1){1'b0}}, reversed_reg};
            default:       prdata = '0;
        endcase
    end

    assign cfg.min_pulse = min_pulse_reg;
    assign cfg.max_pulse = max_pulse_reg;
    assign cfg.max_angle = max_angle_reg;
    assign cfg.reversed  = reversed_reg;

endmodule

// File: sv/sspc_front.sv
// command decode: range checks and percent to angle conversion
module sspc_front import sspc_pkg::*;
(
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [CMD_W-1:0]   command,
    input  logic [ANGLE_W-1:0] value,
    input  cfg_t               cfg,
    input  logic               q_full,
    output logic               q_push,
    output op_t                q_op
);

    logic [PCT_PROD_W-1:0] pct_prod;
    logic [ANGLE_W-1:0]    pct_angle;
    logic                  pct_ok;

    function automatic logic angle_ok(input logic [ANGLE_W-1:0] a,
                                      input logic [ANGLE_W-1:0] lim);
        angle_ok = (a <= lim) && (32'(a) <= 32'(ANGLE_LIMIT));
    endfunction

    assign pct_prod  = PCT_PROD_W'(value) * PCT_PROD_W'(PCT_MUL) + PCT_PROD_W'(PCT_BIAS);
    assign pct_angle = pct_prod[PCT_SHIFT+ANGLE_W-1:PCT_SHIFT];
    assign pct_ok    = 32'(value) <= 32'(PCT_MAX);

    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;

    always_comb
    begin
        q_op.kind  = OP_NOP;
        q_op.angle = '0;
        case (command)
            CMD_TICK:
            begin
                q_op.kind = OP_TICK;
            end
            CMD_GOTO:
            begin
                if (angle_ok(value, cfg.max_angle))
                begin
                    q_op.kind  = OP_GOTO;
                    q_op.angle = value;
                end
            end
            CMD_PCT:
            begin
                if (pct_ok && angle_ok(pct_angle, cfg.max_angle))
                begin
                    q_op.kind  = OP_GOTO;
                    q_op.angle = pct_angle;
                end
            end
            CMD_OPEN:
            begin
                if (angle_ok(cfg.max_angle, cfg.max_angle))
                begin
                    q_op.kind  = OP_GOTO;
                    q_op.angle = cfg.max_angle;
                end
            end
            CMD_CLOSE:
            begin
                q_op.kind = OP_GOTO;
            end
            CMD_STOP:
            begin
                q_op.kind = OP_STOP;
            end
            default:
            begin
                q_op.kind = OP_NOP;
            end
        endcase
    end

endmodule

// File: sv/sspc_queue.sv
// two-entry operation queue between decode and execution
module sspc_queue import sspc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  op_t  push_op,
    input  logic pop,
    output op_t  head_op,
    output logic full,
    output logic empty
);

    op_t               entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign full    = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign empty   = count_reg == '0;
    assign head_op = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// File: sv/sspc_div.sv
// restoring divider, one quotient bit per cycle
module sspc_div import sspc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIVD_W-1:0] dividend,
    input  logic [DIVS_W-1:0] divisor,
    output logic              busy,
    output logic [DIVD_W-1:0] quotient
);

    logic [DIVD_W-1:0] quo_reg;
    logic [DIVS_W-1:0] rem_reg;
    logic [DIVS_W-1:0] dvs_reg;
    logic              busy_reg;
    logic [DCNT_W-1:0] cnt_reg;
    logic [DIVS_W:0]   rem_sh;
    logic              ge;
    logic [DIVS_W:0]   rem_sub;

    assign rem_sh  = {rem_reg, quo_reg[DIVD_W-1]};
    assign ge      = rem_sh >= {1'b0, dvs_reg};
    assign rem_sub = rem_sh - {1'b0, dvs_reg};

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DIVD_W-2:0], ge};
            rem_reg <= ge ? rem_sub[DIVS_W-1:0] : rem_sh[DIVS_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == DCNT_W'(DIVD_W - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

// File: sv/sspc_back.sv
// execution: servo state, slew step, pulse scaling and result register
module sspc_back import sspc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  cfg_t                cfg,
    input  logic                q_empty,
    input  op_t                 q_op,
    output logic                q_pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [PULSE_W-1:0]  pulse_us,
    output logic                pulse_valid,
    output logic [ANGLE_W-1:0]  angle_now,
    output logic [STATUS_W-1:0] status,
    output logic                drive_on,
    output logic                status_event,
    output logic                position_event
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_LOAD = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0]          state_reg, state_next;
    logic [ANGLE_W-1:0]  angle_reg, angle_next;
    logic [ANGLE_W-1:0]  target_reg, target_next;
    logic [STATUS_W-1:0] last_status_reg, last_status_next;
    logic                attached_reg, attached_next;
    logic                ev_status_reg, ev_status_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;

    logic                out_valid_reg;
    logic [PULSE_W-1:0]  pulse_reg, pulse_next;
    logic                pvalid_reg, pvalid_next;
    logic [ANGLE_W-1:0]  angle_out_reg;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic                drive_reg;
    logic                sev_reg, sev_next;
    logic                pev_reg, pev_next;
    logic                out_load;
    logic                slot_free;

    logic [STATUS_W-1:0] tick_st;
    logic                tick_moving;
    logic [ANGLE_W-1:0]  tick_angle;
    logic                tick_arrived;

    logic                span_neg;
    logic [PULSE_W-1:0]  span_mag;
    logic                div_start;
    logic                div_busy;
    logic [DIVD_W-1:0]   div_dividend;
    logic [DIVS_W-1:0]   div_divisor;
    logic [DIVD_W-1:0]   div_quotient;
    logic [DIVD_W-1:0]   q_eff;
    logic signed [RES_W-1:0] lo_s, hi_s, sq, res_fwd, res_mir, res;
    logic [PULSE_W-1:0]  pulse_calc;

    function automatic logic [STATUS_W-1:0] status_of(input logic [ANGLE_W-1:0] a,
                                                      input logic [ANGLE_W-1:0] t);
        if (a == '0)
        begin
            status_of = STAT_CLOSED;
        end
        else if (t < a)
        begin
            status_of = STAT_CLOSING;
        end
        else if (t > a)
        begin
            status_of = STAT_OPENING;
        end
        else
        begin
            status_of = STAT_OPEN;
        end
    endfunction

    assign slot_free    = !out_valid_reg || out_ready;
    assign tick_st      = status_of(angle_reg, target_reg);
    assign tick_moving  = angle_reg != target_reg;
    assign tick_angle   = (angle_reg < target_reg) ? angle_reg + 1'b1 :
                          (angle_reg > target_reg) ? angle_reg - 1'b1 : angle_reg;
    assign tick_arrived = tick_moving && (tick_angle == target_reg);

    assign span_neg     = cfg.max_pulse < cfg.min_pulse;
    assign span_mag     = span_neg ? cfg.min_pulse - cfg.max_pulse
                                   : cfg.max_pulse - cfg.min_pulse;
    assign div_dividend = {prod_reg, 1'b0} + DIVD_W'(cfg.max_angle);
    assign div_divisor  = {cfg.max_angle, 1'b0};

    sspc_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (div_quotient)
    );

    assign q_eff      = (cfg.max_angle == '0) ? '0 : div_quotient;
    assign lo_s       = signed'(RES_W'(cfg.min_pulse));
    assign hi_s       = signed'(RES_W'(cfg.max_pulse));
    assign sq         = span_neg ? -signed'(RES_W'(q_eff)) : signed'(RES_W'(q_eff));
    assign res_fwd    = lo_s + sq;
    assign res_mir    = hi_s + lo_s - res_fwd;
    assign res        = cfg.reversed ? res_mir : res_fwd;
    assign pulse_calc = (res < lo_s || res > hi_s) ? cfg.min_pulse : res[PULSE_W-1:0];

    always_comb
    begin
        state_next       = state_reg;
        angle_next       = angle_reg;
        target_next      = target_reg;
        last_status_next = last_status_reg;
        attached_next    = attached_reg;
        ev_status_next   = ev_status_reg;
        prod_next        = prod_reg;
        q_pop            = 1'b0;
        div_start        = 1'b0;
        out_load         = 1'b0;
        pulse_next       = '0;
        pvalid_next      = 1'b0;
        sev_next         = 1'b0;
        pev_next         = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (!q_empty && slot_free)
                begin
                    q_pop = 1'b1;
                    case (q_op.kind)
                        OP_TICK:
                        begin
                            last_status_next = tick_st;
                            if (tick_moving)
                            begin
                                angle_next     = tick_angle;
                                attached_next  = !tick_arrived;
                                ev_status_next = (last_status_reg != tick_st) || tick_arrived;
                                state_next     = S_MUL;
                            end
                            else
                            begin
                                out_load = 1'b1;
                            end
                        end
                        OP_GOTO:
                        begin
                            target_next = q_op.angle;
                            sev_next    = tick_moving;
                            out_load    = 1'b1;
                        end
                        OP_STOP:
                        begin
                            target_next = angle_reg;
                            sev_next    = 1'b1;
                            out_load    = 1'b1;
                        end
                        default:
                        begin
                            out_load = 1'b1;
                        end
                    endcase
                end
            end
            S_MUL:
            begin
                prod_next  = PROD_W'(angle_reg) * PROD_W'(span_mag);
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                div_start  = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (!div_busy)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (slot_free)
                begin
                    out_load    = 1'b1;
                    pulse_next  = pulse_calc;
                    pvalid_next = 1'b1;
                    sev_next    = ev_status_reg;
                    pev_next    = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        status_next = status_of(angle_next, target_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            angle_reg       <= '0;
            target_reg      <= '0;
            last_status_reg <= STAT_CLOSED;
            attached_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            angle_reg       <= angle_next;
            target_reg      <= target_next;
            last_status_reg <= last_status_next;
            attached_reg    <= attached_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ev_status_reg <= ev_status_next;
        prod_reg      <= prod_next;
        if (out_load)
        begin
            pulse_reg     <= pulse_next;
            pvalid_reg    <= pvalid_next;
            angle_out_reg <= angle_next;
            status_reg    <= status_next;
            drive_reg     <= attached_next;
            sev_reg       <= sev_next;
            pev_reg       <= pev_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign pulse_us       = pulse_reg;
    assign pulse_valid    = pvalid_reg;
    assign angle_now      = angle_out_reg;
    assign status         = status_reg;
    assign drive_on       = drive_reg;
    assign status_event   = sev_reg;
    assign position_event = pev_reg;

endmodule

// File: sv/servo_slew_position_controller_unit.sv
// top level of the servo slew position controller
// commands that do not move the servo pass through the queue into the result register
// a tick that moves the servo steps through S_MUL, S_LOAD, S_DIV (serial divider) and S_FIN to result valid
// throughput: one non-moving command per cycle while the result is taken; a moving tick holds the
// execution stage until its result is loaded, and a two-entry queue keeps input transfers going meanwhile
// reset: angle, target, last status and attachment cleared, queue and result register empty,
// registers back to 544 / 2400 / 270 / not reversed
module servo_slew_position_controller_unit import sspc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [APB_AW-1:0]   paddr,
    input  logic [APB_DW-1:0]   pwdata,
    output logic [APB_DW-1:0]   prdata,
    output logic                pready,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [CMD_W-1:0]    command,
    input  logic [ANGLE_W-1:0]  value,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [PULSE_W-1:0]  pulse_us,
    output logic                pulse_valid,
    output logic [ANGLE_W-1:0]  angle_now,
    output logic [STATUS_W-1:0] status,
    output logic                drive_on,
    output logic                status_event,
    output logic                position_event
);

    cfg_t cfg;
    logic q_full;
    logic q_empty;
    logic q_push;
    logic q_pop;
    op_t  push_op;
    op_t  head_op;

    sspc_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sspc_front u_front
    (
        .in_valid (in_valid),
        .in_ready (in_ready),
        .command  (command),
        .value    (value),
        .cfg      (cfg),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_op     (push_op)
    );

    sspc_queue u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .push_op (push_op),
        .pop     (q_pop),
        .head_op (head_op),
        .full    (q_full),
        .empty   (q_empty)
    );

    sspc_back u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .q_empty        (q_empty),
        .q_op           (head_op),
        .q_pop          (q_pop),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .pulse_us       (pulse_us),
        .pulse_valid    (pulse_valid),
        .angle_now      (angle_now),
        .status         (status),
        .drive_on       (drive_on),
        .status_event   (status_event),
        .position_event (position_event)
    );

endmodule

// File: sv/sspc_chk.sv
// port-level checker for the servo slew position controller, bound to the top level
module sspc_chk
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [11:0] pulse_us,
    input logic        pulse_valid,
    input logic [8:0]  angle_now,
    input logic        drive_on,
    input logic        status_event,
    input logic        position_event
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pulse_us) && $stable(angle_now))
        else $error("result changed while stalled");

    a_no_pulse_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !pulse_valid |-> pulse_us == 12'd0)
        else $error("pulse width without a pulse");

    a_pos_event: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> position_event == pulse_valid)
        else $error("position event does not match a move");

    a_move_drive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && pulse_valid |-> drive_on || status_event)
        else $error("move without drive or arrival");

endmodule

bind servo_slew_position_controller_unit sspc_chk u_sspc_chk (.*);
